[rtl/assert_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define CSC_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("scaler check failed");

// Clocked assertion that also holds while reset is asserted.
`define CSC_ASSERT_RST(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("scaler reset check failed");

`endif

[rtl/csc_pkg.sv]
package csc_pkg;

	localparam logic [1:0] KIND_FIT   = 2'd0;
	localparam logic [1:0] KIND_XFORM = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	localparam int SUM_W = 48;
	localparam int SQ_W  = 64;

	// Clamp limit of 100.0 in Q8.16.
	localparam logic [22:0] Z_LIMIT = 23'd6553600;

	typedef enum logic [1:0] {
		OP_FIT,
		OP_XFORM,
		OP_CLEAR
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t            op;
		logic [5:0]         column;
		logic signed [31:0] sample;
	} cmd_t;

	typedef struct packed {
		logic [5:0]  column;
		logic [23:0] scaled;
		logic        clamped;
		logic        no_data;
	} res_t;

endpackage

[rtl/csc_fifo.sv]
// Two-entry queue of words.
module csc_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);
	logic [W-1:0] mem_q [2];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   cnt_q;
	logic         do_push;
	logic         do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= ~wr_q;
			if (do_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= din;
	end
endmodule

[rtl/csc_divu.sv]
// Restoring divider, one quotient bit per cycle. The dividend arrives
// left-aligned so that only the requested number of steps is run.
module csc_divu (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	input  logic [6:0]  steps,
	output logic        done,
	output logic [63:0] quot,
	output logic [31:0] rem
);
	logic [63:0] acc_q;
	logic [31:0] rem_q;
	logic [31:0] dvs_q;
	logic [6:0]  left_q;
	logic        run_q;
	logic        done_q;
	logic [32:0] trial;
	logic [32:0] diff;
	logic        ge;

	assign trial = {rem_q, acc_q[63]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = (trial >= {1'b0, dvs_q});
	assign done  = done_q;
	assign quot  = acc_q;
	assign rem   = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			left_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				left_q <= steps;
			end else if (run_q) begin
				left_q <= left_q - 7'd1;
				if (left_q == 7'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			acc_q <= {acc_q[62:0], ge};
			rem_q <= ge ? diff[31:0] : trial[31:0];
		end
	end
endmodule

[rtl/csc_sqrt.sv]
// Digit-by-digit integer square root of a 64-bit value, one root bit per cycle.
module csc_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        done,
	output logic [31:0] root
);
	logic [63:0] rad_q;
	logic [35:0] rem_q;
	logic [31:0] root_q;
	logic [5:0]  left_q;
	logic        run_q;
	logic        done_q;
	logic [35:0] cand;
	logic [35:0] trial;
	logic        ge;

	assign cand  = {rem_q[33:0], rad_q[63:62]};
	assign trial = {2'b00, root_q, 2'b01};
	assign ge    = (cand >= trial);
	assign done  = done_q;
	assign root  = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			left_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				left_q <= 6'd32;
			end else if (run_q) begin
				left_q <= left_q - 6'd1;
				if (left_q == 6'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q  <= {rad_q[61:0], 2'b00};
			rem_q  <= ge ? (cand - trial) : cand;
			root_q <= {root_q[30:0], ge};
		end
	end
endmodule

[rtl/csc_front.sv]
// Takes words from the input side, drops those that mean nothing and
// queues the rest as commands for the back end.
module csc_front #(
	parameter int COLUMNS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [1:0]          kind,
	input  logic [5:0]          column,
	input  logic signed [31:0]  sample,
	output csc_pkg::cmd_t       cmd,
	output logic                cmd_empty,
	input  logic                cmd_pop
);
	csc_pkg::cmd_t               cmd_in;
	logic                        keep;
	logic                        col_ok;
	logic [$bits(csc_pkg::cmd_t)-1:0] q_dout;

	assign col_ok = (32'(column) < COLUMNS);

	always_comb begin
		cmd_in.column = column;
		cmd_in.sample = sample;
		cmd_in.op     = csc_pkg::OP_FIT;
		keep          = 1'b0;
		case (kind)
			csc_pkg::KIND_FIT: begin
				cmd_in.op = csc_pkg::OP_FIT;
				keep      = col_ok;
			end
			csc_pkg::KIND_XFORM: begin
				cmd_in.op = csc_pkg::OP_XFORM;
				keep      = col_ok;
			end
			csc_pkg::KIND_CLEAR: begin
				cmd_in.op = csc_pkg::OP_CLEAR;
				keep      = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	csc_fifo #(
		.W($bits(csc_pkg::cmd_t))
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push & keep),
		.din   (cmd_in),
		.full  (full),
		.pop   (cmd_pop),
		.dout  (q_dout),
		.empty (cmd_empty)
	);

	assign cmd = csc_pkg::cmd_t'(q_dout);
endmodule

[rtl/csc_back.sv]
// Executes queued commands against the per-column statistics memories and
// queues the transform results.
module csc_back #(
	parameter int COLUMNS     = 64,
	parameter int MAX_SAMPLES = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  csc_pkg::cmd_t      cmd,
	input  logic               cmd_empty,
	output logic               cmd_pop,
	output csc_pkg::res_t      res,
	output logic               res_empty,
	input  logic               res_pop
);
	localparam int DEPTH = (COLUMNS < 64) ? COLUMNS : 64;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES + 1) : 1;

	typedef struct packed {
		logic [csc_pkg::SUM_W-1:0] sum;
		logic [csc_pkg::SQ_W-1:0]  sq;
		logic [CNT_W-1:0]          cnt;
		logic                      rdy;
	} row_t;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_RD,
		S_FIT_WR,
		S_MEAN_DIV,
		S_MEAN_SQ,
		S_VAR_DIV,
		S_ROOT,
		S_STAT_WR,
		S_Z_GO,
		S_Z_DIV,
		S_EMIT
	} state_t;

	row_t        stat_mem [DEPTH];
	logic [63:0] ms_mem [DEPTH];
	row_t        row_q;
	logic [63:0] ms_q;

	state_t             state_q;
	logic [AW-1:0]      clr_q;
	csc_pkg::cmd_t      cmd_q;
	logic signed [31:0] mean_q;
	logic [31:0]        scale_q;
	logic [47:0]        m2_q;
	csc_pkg::res_t      res_q;
	logic [63:0]        prod_q;

	logic          rd_en;
	logic          st_we;
	logic          ms_we;
	logic [AW-1:0] wa;
	row_t          st_wd;
	logic [31:0]   mul_a;
	logic          div_start;
	logic [63:0]   div_dnd;
	logic [31:0]   div_dvs;
	logic [6:0]    div_steps;
	logic          div_done;
	logic [63:0]   div_quot;
	logic [31:0]   div_rem;
	logic          sq_start;
	logic [63:0]   sq_rad;
	logic          sq_done;
	logic [31:0]   sq_root;
	logic          res_push;
	logic          res_full;
	logic [$bits(csc_pkg::res_t)-1:0] res_dout;

	logic [31:0] ax;
	logic [47:0] abs_sum;
	logic        sum_neg;
	logic [31:0] am;
	logic [31:0] mean_new;
	logic [63:0] var_v;
	logic [32:0] diff;
	logic        z_neg;
	logic [32:0] mag;
	logic        clamp;
	logic [22:0] zv;
	logic [23:0] zs;
	row_t        fit_row;

	// Operands shared by the command states.
	assign ax      = cmd_q.sample[31] ? (32'd0 - cmd_q.sample) : cmd_q.sample;
	assign sum_neg = row_q.sum[47];
	assign abs_sum = sum_neg ? (48'd0 - row_q.sum) : row_q.sum;
	assign am      = div_quot[31:0] + {31'd0, sum_neg & (div_rem != 32'd0)};
	assign mean_new = sum_neg ? (32'd0 - am) : am;
	assign var_v   = (div_quot > {16'd0, m2_q}) ? (div_quot - {16'd0, m2_q}) : 64'd0;
	assign diff    = {cmd_q.sample[31], cmd_q.sample} - {mean_q[31], mean_q};
	assign z_neg   = diff[32];
	assign mag     = z_neg ? (33'd0 - diff) : diff;
	assign clamp   = (div_quot > {41'd0, csc_pkg::Z_LIMIT});
	assign zv      = clamp ? csc_pkg::Z_LIMIT : div_quot[22:0];
	assign zs      = z_neg ? (24'd0 - {1'b0, zv}) : {1'b0, zv};

	always_comb begin
		fit_row.sum = row_q.sum + {{16{cmd_q.sample[31]}}, cmd_q.sample};
		fit_row.sq  = row_q.sq + {16'd0, prod_q[63:16]};
		fit_row.cnt = row_q.cnt + CNT_W'(1);
		fit_row.rdy = 1'b0;
	end

	always_comb begin
		rd_en     = 1'b0;
		cmd_pop   = 1'b0;
		st_we     = 1'b0;
		ms_we     = 1'b0;
		wa        = cmd_q.column[AW-1:0];
		st_wd     = row_q;
		mul_a     = ax;
		div_start = 1'b0;
		div_dnd   = {abs_sum, 16'd0};
		div_dvs   = 32'(row_q.cnt);
		div_steps = 7'd48;
		sq_start  = 1'b0;
		sq_rad    = {var_v[47:0], 16'd0};
		res_push  = 1'b0;
		case (state_q)
			S_CLR: begin
				st_we = 1'b1;
				wa    = clr_q;
				st_wd = '0;
			end
			S_IDLE: begin
				cmd_pop = ~cmd_empty;
				rd_en   = ~cmd_empty;
			end
			S_RD: begin
				div_start = (cmd_q.op == csc_pkg::OP_XFORM) && (row_q.cnt != '0) && !row_q.rdy;
			end
			S_FIT_WR: begin
				st_we = 1'b1;
				st_wd = fit_row;
			end
			S_MEAN_DIV: begin
				mul_a = am;
			end
			S_MEAN_SQ: begin
				div_start = 1'b1;
				div_dnd   = row_q.sq;
				div_steps = 7'd64;
			end
			S_VAR_DIV: begin
				sq_start = div_done;
			end
			S_STAT_WR: begin
				st_we     = 1'b1;
				st_wd.rdy = 1'b1;
				ms_we     = 1'b1;
			end
			S_Z_GO: begin
				div_start = 1'b1;
				div_dnd   = {mag, 31'd0};
				div_dvs   = scale_q;
				div_steps = 7'd49;
			end
			S_EMIT: begin
				res_push = ~res_full;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_we) stat_mem[wa] <= st_wd;
		if (ms_we) ms_mem[wa] <= {mean_q, scale_q};
		if (rd_en) begin
			row_q <= stat_mem[cmd.column[AW-1:0]];
			ms_q  <= ms_mem[cmd.column[AW-1:0]];
		end
		prod_q <= 64'(mul_a) * 64'(mul_a);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			cmd_q   <= '0;
			mean_q  <= '0;
			scale_q <= '0;
			m2_q    <= '0;
			res_q   <= '0;
		end else begin
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (!cmd_empty) begin
						cmd_q <= cmd;
						clr_q <= '0;
						state_q <= (cmd.op == csc_pkg::OP_CLEAR) ? S_CLR : S_RD;
					end
				end
				S_RD: begin
					if (cmd_q.op == csc_pkg::OP_FIT) begin
						state_q <= (row_q.cnt >= CNT_W'(MAX_SAMPLES)) ? S_IDLE : S_FIT_WR;
					end else if (row_q.cnt == '0) begin
						res_q.column  <= cmd_q.column;
						res_q.scaled  <= '0;
						res_q.clamped <= 1'b0;
						res_q.no_data <= 1'b1;
						state_q       <= S_EMIT;
					end else if (row_q.rdy) begin
						mean_q  <= ms_q[63:32];
						scale_q <= ms_q[31:0];
						state_q <= S_Z_GO;
					end else begin
						state_q <= S_MEAN_DIV;
					end
				end
				S_FIT_WR: state_q <= S_IDLE;
				S_MEAN_DIV: begin
					if (div_done) begin
						mean_q  <= mean_new;
						state_q <= S_MEAN_SQ;
					end
				end
				S_MEAN_SQ: begin
					m2_q    <= prod_q[63:16];
					state_q <= S_VAR_DIV;
				end
				S_VAR_DIV: begin
					if (div_done) state_q <= S_ROOT;
				end
				S_ROOT: begin
					if (sq_done) begin
						scale_q <= sq_root + 32'd1;
						state_q <= S_STAT_WR;
					end
				end
				S_STAT_WR: state_q <= S_Z_GO;
				S_Z_GO: state_q <= S_Z_DIV;
				S_Z_DIV: begin
					if (div_done) begin
						res_q.column  <= cmd_q.column;
						res_q.scaled  <= zs;
						res_q.clamped <= clamp;
						res_q.no_data <= 1'b0;
						state_q       <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!res_full) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	csc_divu u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dnd),
		.divisor (div_dvs),
		.steps   (div_steps),
		.done    (div_done),
		.quot    (div_quot),
		.rem     (div_rem)
	);

	csc_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sq_start),
		.radicand(sq_rad),
		.done    (sq_done),
		.root    (sq_root)
	);

	csc_fifo #(
		.W($bits(csc_pkg::res_t))
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.din   (res_q),
		.full  (res_full),
		.pop   (res_pop),
		.dout  (res_dout),
		.empty (res_empty)
	);

	assign res = csc_pkg::res_t'(res_dout);
endmodule

[rtl/column_standard_scaler.sv]
// Channel   Handshake              Word
// input     push / full            kind, column, sample (signed Q16.16)
// result    pop / empty            column_out, scaled (signed Q8.16), clamped, no_data
//
// A fit word passes through command fetch, statistics read and write-back in
// the back end. A transform of a column whose statistics are current runs the
// 49 steps of the one-bit-per-cycle divider. A transform after new fit data
// also runs the mean division (48 steps), the mean-of-squares division (64
// steps) and the 32-step square root. A clear word sweeps the statistics
// memory, one column a cycle, over min(COLUMNS, 64) columns; the same sweep
// runs after reset, while no word is taken from the queue.
// A two-word queue on each side lets the input keep accepting while a result
// waits, and the back end keeps working until its result queue is full.
module column_standard_scaler #(
	parameter int COLUMNS     = 64,
	parameter int MAX_SAMPLES = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         kind,
	input  logic [5:0]         column,
	input  logic signed [31:0] sample,
	output logic               empty,
	input  logic               pop,
	output logic [5:0]         column_out,
	output logic signed [23:0] scaled,
	output logic               clamped,
	output logic               no_data
);
	// Command queue between the front end and the back end.
	csc_pkg::cmd_t cmd;
	logic          cmd_empty;
	logic          cmd_pop;
	csc_pkg::res_t res;

	// The front end classifies each word and discards unused kinds, and fit and
	// transform words for columns beyond the configured range, so they never reach the back end.
	csc_front #(
		.COLUMNS(COLUMNS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.kind     (kind),
		.column   (column),
		.sample   (sample),
		.cmd      (cmd),
		.cmd_empty(cmd_empty),
		.cmd_pop  (cmd_pop)
	);

	// The back end holds the statistics and computes mean, scale and the
	// standardised value, one command at a time.
	csc_back #(
		.COLUMNS    (COLUMNS),
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cmd_empty(cmd_empty),
		.cmd_pop  (cmd_pop),
		.res      (res),
		.res_empty(empty),
		.res_pop  (pop)
	);

	assign column_out = res.column;
	assign scaled     = signed'(res.scaled);
	assign clamped    = res.clamped;
	assign no_data    = res.no_data;
endmodule

[rtl/csc_checker.sv]
`include "assert_macros.svh"

module csc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input logic [5:0]         column_out,
	input logic signed [23:0] scaled,
	input logic               clamped,
	input logic               no_data
);
	localparam logic signed [23:0] Z_LIM = 24'sd6553600;

	// The whole result word, so that its stability is checked in one go.
	logic [31:0] res_word;

	assign res_word = {column_out, scaled, clamped, no_data};

	// No result is offered while reset is held.
	`CSC_ASSERT_RST(a_empty_in_reset, clk, !arst_n |-> empty)

	// A result that is not taken stays in place unchanged.
	`CSC_ASSERT(a_result_holds, clk, arst_n, (!empty && !pop) |=> (!empty && $stable(res_word)))

	// An empty column gives zero and is never flagged as clamped.
	`CSC_ASSERT(a_no_data_zero, clk, arst_n, (!empty && no_data) |-> (scaled == 24'sd0 && !clamped))

	// A clamped value sits exactly on one of the two limits.
	`CSC_ASSERT(a_clamp_limit, clk, arst_n, (!empty && clamped) |-> (scaled == Z_LIM || scaled == -Z_LIM))
endmodule

bind column_standard_scaler csc_checker u_csc_checker (.*);

[test/tb.sv]
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NCOL = 64;
	localparam int MAXN = 65536;
	localparam int ZLIM = 6553600;
	// Settling time after the queue drains, with margin for a transform after new fit data.
	localparam int DRAIN_CYCLES = 400;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	typedef struct {
		logic [5:0]  column;
		logic [23:0] scaled;
		logic        clamped;
		logic        no_data;
	} scaled_word_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b1;
	logic               push = 1'b0;
	logic               full;
	logic [1:0]         kind = csc_pkg::KIND_FIT;
	logic [5:0]         column = '0;
	logic signed [31:0] sample = '0;
	logic               empty;
	logic               pop = 1'b0;
	logic [5:0]         column_out;
	logic signed [23:0] scaled;
	logic               clamped;
	logic               no_data;

	// Idling percentages of the two sides, changed between phases.
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	int unsigned fail_count = 0;
	int unsigned words_sent = 0;
	int unsigned words_checked = 0;

	// Predictor state: a copy of the per-column statistics.
	logic signed [47:0] sum_of_col   [NCOL];
	logic [63:0]        sumsq_of_col [NCOL];
	int unsigned        count_of_col [NCOL];
	logic signed [31:0] mean_of_col  [NCOL];
	logic [31:0]        scale_of_col [NCOL];
	bit                 stats_fresh  [NCOL];

	scaled_word_t expected_words[$];

	column_standard_scaler dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.kind(kind),
		.column(column),
		.sample(sample),
		.empty(empty),
		.pop(pop),
		.column_out(column_out),
		.scaled(scaled),
		.clamped(clamped),
		.no_data(no_data)
	);

	always #5 clk = ~clk;

	// Integer square root, one result bit per pass.
	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] root;
		logic [63:0] bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v = v - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	// Mean (floored), population variance and scale of one column.
	function automatic void refresh_stats(input int c);
		longint signed n;
		longint signed s;
		longint signed q;
		logic [63:0] am;
		logic [63:0] m2;
		logic [63:0] ex2;
		logic [63:0] var_q;
		n = count_of_col[c];
		s = sum_of_col[c];
		q = s / n;
		if ((s % n) != 0 && s < 0) q = q - 1;
		mean_of_col[c] = q[31:0];
		am = (q < 0) ? -q : q;
		m2 = (am * am) >> 16;
		ex2 = sumsq_of_col[c] / n;
		var_q = (ex2 > m2) ? ex2 - m2 : 64'd0;
		scale_of_col[c] = 32'(int_sqrt(var_q << 16) + 64'd1);
		stats_fresh[c] = 1'b1;
	endfunction

	function automatic void clear_stats();
		for (int c = 0; c < NCOL; c++) begin
			sum_of_col[c] = '0;
			sumsq_of_col[c] = '0;
			count_of_col[c] = 0;
			stats_fresh[c] = 1'b0;
		end
	endfunction

	// Applies one accepted word to the predictor and queues its result, if any.
	function automatic void predict_word(input logic [1:0] k, input logic [5:0] c,
			input logic signed [31:0] x);
		scaled_word_t w;
		longint signed diff;
		logic [63:0] mag;
		logic [63:0] zq;
		logic neg;
		logic [63:0] ax;
		case (k)
			csc_pkg::KIND_CLEAR: begin
				clear_stats();
			end
			csc_pkg::KIND_FIT: begin
				if (count_of_col[c] < MAXN) begin
					ax = (x < 0) ? -longint'(x) : longint'(x);
					sum_of_col[c] = sum_of_col[c] + x;
					sumsq_of_col[c] = sumsq_of_col[c] + ((ax * ax) >> 16);
					count_of_col[c]++;
					stats_fresh[c] = 1'b0;
				end
			end
			csc_pkg::KIND_XFORM: begin
				w.column = c;
				if (count_of_col[c] == 0) begin
					w.scaled = '0;
					w.clamped = 1'b0;
					w.no_data = 1'b1;
				end else begin
					if (!stats_fresh[c]) refresh_stats(c);
					diff = longint'(x) - longint'(mean_of_col[c]);
					neg = diff < 0;
					mag = neg ? -diff : diff;
					zq = (mag << 16) / scale_of_col[c];
					w.clamped = zq > ZLIM;
					if (w.clamped) zq = ZLIM;
					w.scaled = neg ? 24'(-zq) : 24'(zq);
					w.no_data = 1'b0;
				end
				expected_words.insert(expected_words.size(), w);
			end
			default: begin
				// The unused kind is ignored.
			end
		endcase
	endfunction

	// Sends one word: optional idle cycles, then hold push until it is taken.
	// Push stays high after acceptance so that words can follow back to back.
	task automatic send_word(input logic [1:0] k, input logic [5:0] c,
			input logic signed [31:0] x);
		if ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
		push <= 1'b1;
		kind <= k;
		column <= c;
		sample <= x;
		@(posedge clk);
		while (full) @(posedge clk);
		predict_word(k, c, x);
		words_sent++;
	endtask

	// Waits until every expected word has come back, then lets the back end settle.
	task automatic drain();
		push <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// The receiver stalls at random; each accepted word is compared with the oldest
	// expectation.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_words.size() == 0) begin
					$error("unexpected word: column_out %0d scaled %0d", column_out, scaled);
					fail_count++;
				end else begin
					scaled_word_t e;
					e = expected_words.pop_front();
					if (column_out !== e.column) begin
						$error("column_out: expected %0d, actual %0d", e.column, column_out);
						fail_count++;
					end
					if (scaled !== e.scaled) begin
						$error("scaled: expected %0d, actual %0d",
							$signed(e.scaled), scaled);
						fail_count++;
					end
					if (clamped !== e.clamped) begin
						$error("clamped: expected %0b, actual %0b", e.clamped, clamped);
						fail_count++;
					end
					if (no_data !== e.no_data) begin
						$error("no_data: expected %0b, actual %0b", e.no_data, no_data);
						fail_count++;
					end
					words_checked++;
				end
			end
			pop <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic logic signed [31:0] rand_sample();
		// Mostly moderate values so that the z values stay interesting, with a few
		// full-range ones to exercise every bit and the clamp.
		case ($urandom_range(9))
			0, 1: return $urandom();
			2: return $signed(32'($urandom_range(65535))) - 32768;
			default: return $signed(32'($urandom_range(32'h000fffff))) - 32'sh00080000;
		endcase
	endfunction

	// Extremes of the sample, every kind, the empty column, clamping and clear.
	task automatic test_directed();
		send_word(csc_pkg::KIND_XFORM, 6'd5, 32'sd0);
		send_word(csc_pkg::KIND_FIT, 6'd0, 32'sh7fffffff);
		send_word(csc_pkg::KIND_FIT, 6'd0, 32'sh80000000);
		send_word(csc_pkg::KIND_XFORM, 6'd0, 32'sh7fffffff);
		send_word(csc_pkg::KIND_XFORM, 6'd0, 32'sh80000000);
		send_word(csc_pkg::KIND_FIT, 6'd63, 32'sh00010000);
		send_word(csc_pkg::KIND_XFORM, 6'd63, 32'sh00010000);
		send_word(csc_pkg::KIND_XFORM, 6'd63, 32'sh00010001);
		send_word(csc_pkg::KIND_XFORM, 6'd63, 32'shffff0000);
		send_word(csc_pkg::KIND_FIT, 6'd1, 32'sh00020000);
		send_word(csc_pkg::KIND_FIT, 6'd1, 32'shfffe0000);
		send_word(csc_pkg::KIND_XFORM, 6'd1, 32'sh00010000);
		send_word(csc_pkg::KIND_XFORM, 6'd1, 32'sh01000000);
		send_word(csc_pkg::KIND_XFORM, 6'd1, 32'shff000000);
		send_word(KIND_UNUSED, 6'd1, 32'sh12345678);
		send_word(csc_pkg::KIND_CLEAR, 6'd0, 32'sd0);
		send_word(csc_pkg::KIND_XFORM, 6'd1, 32'sd0);
		send_word(csc_pkg::KIND_FIT, 6'd1, -32'sd3);
		send_word(csc_pkg::KIND_XFORM, 6'd1, 32'sd0);
		drain();
	endtask

	// Load one column with many full-range samples so that the sums grow large.
	task automatic test_long_column();
		for (int i = 0; i < 100; i++)
			send_word(csc_pkg::KIND_FIT, 6'd9, $urandom());
		send_word(csc_pkg::KIND_XFORM, 6'd9, 32'sh7fffffff);
		send_word(csc_pkg::KIND_XFORM, 6'd9, 32'sh80000000);
		send_word(csc_pkg::KIND_XFORM, 6'd9, 32'sh00004000);
		drain();
	endtask

	// Random mix, mostly fit then transform on a few busy columns.
	task automatic test_random(input int n, input int unsigned idle, input int unsigned stall);
		logic [1:0] k;
		logic [5:0] c;
		int unsigned r;
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			k = (r < 55) ? csc_pkg::KIND_FIT : (r < 97) ? csc_pkg::KIND_XFORM :
				(r < 99) ? csc_pkg::KIND_CLEAR : KIND_UNUSED;
			c = ($urandom_range(3) == 0) ? 6'($urandom()) : 6'($urandom_range(7));
			send_word(k, c, rand_sample());
		end
		drain();
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		clear_stats();
		test_directed();
		test_random(320, 0, 0);
		test_random(320, 74, 0);
		test_random(320, 0, 74);
		test_random(320, 13, 13);
		test_long_column();
		$display("Sent %0d words (random kinds, columns and samples under four idling",
			words_sent);
		$display("phases, plus one column loaded with full-range samples); %0d checked.",
			words_checked);
		if (fail_count == 0 && expected_words.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Limit: a timeout for the roughly 1400 words sent by all tests.
	initial begin
		#30ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire

[column_standard_scaler.f]
+incdir+rtl
rtl/csc_pkg.sv
rtl/csc_fifo.sv
rtl/csc_divu.sv
rtl/csc_sqrt.sv
rtl/csc_front.sv
rtl/csc_back.sv
rtl/column_standard_scaler.sv
rtl/csc_checker.sv
test/tb.sv
